// ===== rtl/core/mur64_pkg.sv =====
// Package for the streaming 64-bit multiply-xorshift hash core.
// Holds the hash constants, the controller-to-datapath command type and the tail mask.
// No dependencies.
package mur64_pkg;

	localparam logic [63:0] MUR_MULT  = 64'hC6A4A7935BD1E995;
	localparam logic [63:0] MUR_SEED  = 64'hA06A43342758469B;
	localparam int          MUR_SHIFT = 47;

	typedef enum logic [1:0] {
		MS_NONE,
		MS_P0,
		MS_P1,
		MS_P2
	} mul_step_t;

	typedef enum logic [1:0] {
		SRC_LEN,
		SRC_W,
		SRC_H_TAIL,
		SRC_H_SHIFT
	} mul_src_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_SEED,
		WB_WMIX,
		WB_WSET,
		WB_HSET,
		WB_OUT
	} wb_sel_t;

	typedef struct packed {
		logic      capture;
		mul_step_t step;
		mul_src_t  src;
		wb_sel_t   wb;
	} dp_cmd_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (cnt > 4'(i)) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [63:0] xsh(input logic [63:0] v);
		return v ^ (v >> MUR_SHIFT);
	endfunction

endpackage

// ===== rtl/core/murmur64a_stream_hash_top.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   data_word, byte_count, is_last, message_length
// out      output     out_valid / out_stall hash_value
//
// One item at a time; a 64-bit product by the constant is built on the one
// 32x32 multiplier. A full word runs the WMUL1, WMUL2 and HMUL products, a tail one;
// the first item of a message adds the seed product; the last adds the final avalanche.
// Reset clears the controller; the result waits in its register while the next
// message is taken, and only the next result's write holds on a stalled output.
// Depends on mur64_pkg, mur64_ctrl, mur64_datapath.
module murmur64a_stream_hash_top
	import mur64_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        is_last,
	input  logic [31:0] message_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	dp_cmd_t cmd;

	mur64_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_count (byte_count),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd)
	);

	mur64_datapath u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.message_length (message_length),
		.hash_value     (hash_value)
	);

endmodule

// ===== rtl/core/mur64_datapath.sv =====
// Datapath of the hash core: running hash, work word, operand and accumulator registers.
// One 32x32 multiplier builds each 64-bit product by the constant over three steps.
// Depends on mur64_pkg.
module mur64_datapath
	import mur64_pkg::*;
(
	input  logic        clk,
	input  dp_cmd_t     cmd,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic [31:0] message_length,
	output logic [63:0] hash_value
);

	logic [63:0] h_q;
	logic [63:0] w_q;
	logic [31:0] len_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;

	logic [63:0] src;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] acc_n;

	always_comb begin
		case (cmd.src)
			SRC_LEN:     src = {32'd0, len_q};
			SRC_W:       src = w_q;
			SRC_H_TAIL:  src = h_q ^ w_q;
			SRC_H_SHIFT: src = xsh(h_q);
			default:     src = w_q;
		endcase
	end

	always_comb begin
		case (cmd.step)
			MS_P0:   begin mul_a = src[31:0];   mul_b = MUR_MULT[31:0];  end
			MS_P1:   begin mul_a = a_q[31:0];   mul_b = MUR_MULT[63:32]; end
			MS_P2:   begin mul_a = a_q[63:32];  mul_b = MUR_MULT[31:0];  end
			default: begin mul_a = a_q[31:0];   mul_b = MUR_MULT[31:0];  end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
		if (cmd.step == MS_P0) begin
			acc_n = prod;
		end else begin
			acc_n = acc_q + {prod[31:0], 32'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			w_q   <= data_word & byte_mask(byte_count);
			len_q <= message_length;
		end
		if (cmd.step != MS_NONE) begin
			acc_q <= acc_n;
		end
		if (cmd.step == MS_P0) begin
			a_q <= src;
		end
		if (cmd.step == MS_P2) begin
			case (cmd.wb)
				WB_SEED: h_q   <= MUR_SEED ^ acc_n;
				WB_WMIX: w_q   <= xsh(acc_n);
				WB_WSET: w_q   <= acc_n;
				WB_HSET: h_q   <= acc_n;
				WB_OUT:  res_q <= xsh(acc_n);
				default: ;
			endcase
		end
	end

	assign hash_value = res_q;

endmodule

// ===== rtl/core/mur64_ctrl.sv =====
// Controller of the hash core: sequences seed, word mix, tail and final avalanche.
// Drives the datapath by command and owns the input and output handshakes.
// Depends on mur64_pkg.
module mur64_ctrl
	import mur64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] byte_count,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEED,
		S_WMUL1,
		S_WMUL2,
		S_HMUL,
		S_TAIL,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		K_EMPTY,
		K_PART,
		K_FULL
	} kind_t;

	state_t    state_q;
	mul_step_t ph_q;
	kind_t     kind_q;
	logic      ends_q;
	logic      in_msg_q;
	logic      out_valid_q;

	kind_t  in_kind;
	logic   in_ends;
	logic   accept;
	logic   hold;
	logic   last_ph;
	logic   fin_done;
	state_t after_seed;
	state_t after_word;

	always_comb begin
		if (byte_count >= 4'd8) begin
			in_kind = K_FULL;
		end else if (byte_count == 4'd0) begin
			in_kind = K_EMPTY;
		end else begin
			in_kind = K_PART;
		end
		in_ends = is_last || (in_kind == K_PART);
	end

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign hold     = (state_q == S_FIN) && (ph_q == MS_P2) && out_valid_q && out_stall;
	assign last_ph  = (ph_q == MS_P2) && !hold;
	assign fin_done = (state_q == S_FIN) && last_ph;

	always_comb begin
		unique case (kind_q)
			K_FULL:  after_seed = S_WMUL1;
			K_PART:  after_seed = S_TAIL;
			default: after_seed = ends_q ? S_FIN : S_IDLE;
		endcase
		after_word = ends_q ? S_FIN : S_IDLE;
	end

	always_comb begin
		cmd.capture = accept;
		cmd.step    = MS_NONE;
		cmd.src     = SRC_W;
		cmd.wb      = WB_NONE;
		unique case (state_q)
			S_SEED:  begin cmd.src = SRC_LEN;     cmd.wb = WB_SEED; end
			S_WMUL1: begin cmd.src = SRC_W;       cmd.wb = WB_WMIX; end
			S_WMUL2: begin cmd.src = SRC_W;       cmd.wb = WB_WSET; end
			S_HMUL:  begin cmd.src = SRC_H_TAIL;  cmd.wb = WB_HSET; end
			S_TAIL:  begin cmd.src = SRC_H_TAIL;  cmd.wb = WB_HSET; end
			S_FIN:   begin cmd.src = SRC_H_SHIFT; cmd.wb = WB_OUT;  end
			default: ;
		endcase
		if (state_q != S_IDLE && !hold) begin
			cmd.step = ph_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= MS_P0;
			kind_q      <= K_EMPTY;
			ends_q      <= 1'b0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					ph_q <= MS_P0;
					if (accept) begin
						kind_q   <= in_kind;
						ends_q   <= in_ends;
						in_msg_q <= !in_ends;
						if (!in_msg_q) begin
							state_q <= S_SEED;
						end else begin
							unique case (in_kind)
								K_FULL:  state_q <= S_WMUL1;
								K_PART:  state_q <= S_TAIL;
								default: state_q <= in_ends ? S_FIN : S_IDLE;
							endcase
						end
					end
				end
				default: begin
					if (!hold) begin
						unique case (ph_q)
							MS_P0:   ph_q <= MS_P1;
							MS_P1:   ph_q <= MS_P2;
							default: ph_q <= MS_P0;
						endcase
					end
					if (last_ph) begin
						unique case (state_q)
							S_SEED:  state_q <= after_seed;
							S_WMUL1: state_q <= S_WMUL2;
							S_WMUL2: state_q <= S_HMUL;
							S_HMUL:  state_q <= after_word;
							S_TAIL:  state_q <= S_FIN;
							default: state_q <= S_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
